@@ sv/erpt_pkg.sv @@
// ----------------------------------------------------------------------------
// erpt_pkg: shared types and constants
// Angle constants, CORDIC table, queue word layout and the product schedule
// of the rigid point transform.
// ----------------------------------------------------------------------------
package erpt_pkg;

    // Angles in Q16.16 degrees, carried as 28-bit signed values
    localparam logic signed [27:0] DEG360 = 28'sd23592960;
    localparam logic signed [27:0] DEG180 = 28'sd11796480;
    localparam logic signed [27:0] DEG90  = 28'sd5898240;

    // CORDIC gain in Q30
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    // Product schedule: matrix products first, then the point products
    localparam logic [4:0] MAT_STEPS = 5'd14;
    localparam logic [4:0] LAST_STEP = 5'd22;

    // Destinations besides the nine matrix entries
    localparam logic [3:0] DST_TA = 4'd9;
    localparam logic [3:0] DST_TB = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TRIG, ST_MAT, ST_DRAIN, ST_ROUND, ST_SCALE, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        SRC_CY, SRC_SY, SRC_CP, SRC_SP, SRC_CR, SRC_SR, SRC_TA, SRC_TB
    } t_src;

    typedef enum logic [1:0] {
        WB_SET, WB_ADD, WB_SUB
    } t_wb;

    typedef struct packed {
        t_src       a;
        t_src       b;
        logic [3:0] dst;
        t_wb        mode;
    } t_mop;

    // One queued word: point, offset, reduced angles (roll, pitch, yaw)
    typedef struct packed {
        logic [2:0][31:0] cam;
        logic [2:0][31:0] eff;
        logic [2:0][27:0] ang;
        logic [2:0]       negc;
    } t_item;

    // arctan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58665;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Matrix product schedule; entries are row-major m[3*row+col]
    function automatic t_mop mat_op(input logic [4:0] s);
        t_mop op;
        case (s)
            5'd0:    op = '{SRC_CY, SRC_SP, DST_TA, WB_SET};
            5'd1:    op = '{SRC_SY, SRC_SP, DST_TB, WB_SET};
            5'd2:    op = '{SRC_CY, SRC_CP, 4'd0, WB_SET};
            5'd3:    op = '{SRC_SY, SRC_CP, 4'd3, WB_SET};
            5'd4:    op = '{SRC_CP, SRC_SR, 4'd7, WB_SET};
            5'd5:    op = '{SRC_CP, SRC_CR, 4'd8, WB_SET};
            5'd6:    op = '{SRC_TA, SRC_SR, 4'd1, WB_SET};
            5'd7:    op = '{SRC_SY, SRC_CR, 4'd1, WB_SUB};
            5'd8:    op = '{SRC_TA, SRC_CR, 4'd2, WB_SET};
            5'd9:    op = '{SRC_SY, SRC_SR, 4'd2, WB_ADD};
            5'd10:   op = '{SRC_TB, SRC_SR, 4'd4, WB_SET};
            5'd11:   op = '{SRC_CY, SRC_CR, 4'd4, WB_ADD};
            5'd12:   op = '{SRC_TB, SRC_CR, 4'd5, WB_SET};
            5'd13:   op = '{SRC_CY, SRC_SR, 4'd5, WB_SUB};
            default: op = '{SRC_CY, SRC_CY, DST_TA, WB_SET};
        endcase
        return op;
    endfunction

    // Row and column of a point product index
    function automatic logic [1:0] pt_row(input logic [3:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pt_col(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

@@ sv/erpt_front.sv @@
// ----------------------------------------------------------------------------
// erpt_front: input side
// Accepts words, reduces the three angles into [-90, 90] degrees with a
// cosine sign flag, and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module erpt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   i_cam_x,
    input  logic signed [31:0]   i_cam_y,
    input  logic signed [31:0]   i_cam_z,
    input  logic signed [31:0]   i_eff_x,
    input  logic signed [31:0]   i_eff_y,
    input  logic signed [31:0]   i_eff_z,
    input  logic signed [25:0]   i_roll_deg,
    input  logic signed [25:0]   i_pitch_deg,
    input  logic signed [25:0]   i_yaw_deg,
    output logic                 o_vld,
    output erpt_pkg::t_item      o_item,
    input  logic                 i_pop
);

    typedef struct packed {
        logic [27:0] ang;
        logic        neg;
    } t_red;

    // Wrap into [-180, 180), then fold beyond +-90 and flag the cosine
    function automatic t_red reduce(input logic signed [25:0] a);
        logic signed [27:0] r;
        t_red               res;
        r = 28'(a);
        if (r < -erpt_pkg::DEG360) begin
            r = r + erpt_pkg::DEG360 + erpt_pkg::DEG360;
        end else if (r < 28'sd0) begin
            r = r + erpt_pkg::DEG360;
        end else if (r >= erpt_pkg::DEG360) begin
            r = r - erpt_pkg::DEG360;
        end
        if (r >= erpt_pkg::DEG180) begin
            r = r - erpt_pkg::DEG360;
        end
        res.neg = 1'b0;
        if (r > erpt_pkg::DEG90) begin
            r = erpt_pkg::DEG180 - r;
            res.neg = 1'b1;
        end else if (r < -erpt_pkg::DEG90) begin
            r = -erpt_pkg::DEG180 - r;
            res.neg = 1'b1;
        end
        res.ang = r;
        return res;
    endfunction

    erpt_pkg::t_item w_item;
    t_red            w_red [3];
    erpt_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_wr, w_rd;

    // Classify the incoming word
    always_comb begin
        w_red[0] = reduce(i_roll_deg);
        w_red[1] = reduce(i_pitch_deg);
        w_red[2] = reduce(i_yaw_deg);
        w_item.cam[0] = i_cam_x;
        w_item.cam[1] = i_cam_y;
        w_item.cam[2] = i_cam_z;
        w_item.eff[0] = i_eff_x;
        w_item.eff[1] = i_eff_y;
        w_item.eff[2] = i_eff_z;
        for (int k = 0; k < 3; k++) begin
            w_item.ang[k]  = w_red[k].ang;
            w_item.negc[k] = w_red[k].neg;
        end
    end

    assign full   = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
    assign w_wr   = push && !full;
    assign w_rd   = i_pop && o_vld;

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= w_item;
    end

endmodule

@@ sv/erpt_engine.sv @@
// ----------------------------------------------------------------------------
// erpt_engine: back end
// Three CORDIC units for sine and cosine, one shared 32x32 multiplier that
// builds the rotation matrix and the point products, then scale and offset.
// ----------------------------------------------------------------------------
module erpt_engine #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  erpt_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   o_world_x,
    output logic signed [31:0]   o_world_y,
    output logic signed [31:0]   o_world_z,
    output logic                 o_saturated
);

    localparam int CW = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;

    erpt_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [4:0]        r_step;
    logic              r_wb_vld;
    logic [4:0]        r_wb_step;
    logic              r_out_vld;
    logic              w_out_load;

    logic signed [33:0] r_x [3];
    logic signed [33:0] r_y [3];
    logic signed [27:0] r_z [3];
    logic               r_negc [3];
    logic signed [31:0] r_cam [3];
    logic signed [31:0] r_eff [3];
    logic signed [33:0] r_m [9];
    logic signed [31:0] r_ta, r_tb;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc [3];
    logic signed [45:0] r_t [3];
    logic signed [47:0] r_w [3];
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic               r_osat;

    logic signed [31:0] w_sin [3];
    logic signed [31:0] w_cos [3];
    logic [4:0]         w_sh;
    logic signed [27:0] w_at;
    erpt_pkg::t_mop     w_op, w_wb_op;
    logic [3:0]         w_idx, w_wb_idx;
    logic signed [31:0] w_a, w_b;
    logic signed [33:0] w_rv;
    logic signed [55:0] w_p [3];
    logic signed [47:0] w_wv [3];
    logic signed [31:0] w_sat [3];
    logic               w_any_sat;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            erpt_pkg::ST_IDLE:  if (i_q_vld) n_state = erpt_pkg::ST_TRIG;
            erpt_pkg::ST_TRIG:  if (r_cnt == CW'(TRIG_STEPS - 1)) n_state = erpt_pkg::ST_MAT;
            erpt_pkg::ST_MAT:   if (r_step == erpt_pkg::LAST_STEP) n_state = erpt_pkg::ST_DRAIN;
            erpt_pkg::ST_DRAIN: n_state = erpt_pkg::ST_ROUND;
            erpt_pkg::ST_ROUND: n_state = erpt_pkg::ST_SCALE;
            erpt_pkg::ST_SCALE: n_state = erpt_pkg::ST_OUT;
            erpt_pkg::ST_OUT:   if (w_out_load) n_state = erpt_pkg::ST_IDLE;
            default:            n_state = erpt_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_q_pop    = (r_state == erpt_pkg::ST_IDLE) && i_q_vld;
        w_out_load = (r_state == erpt_pkg::ST_OUT) && (!r_out_vld || pop);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= erpt_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_step    <= '0;
            r_wb_vld  <= 1'b0;
            r_wb_step <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wb_vld  <= (r_state == erpt_pkg::ST_MAT);
            r_wb_step <= r_step;
            if (r_state == erpt_pkg::ST_TRIG) r_cnt <= r_cnt + CW'(1);
            else                              r_cnt <= '0;
            if (r_state == erpt_pkg::ST_MAT)  r_step <= r_step + 5'd1;
            else                              r_step <= '0;
            if (w_out_load)                   r_out_vld <= 1'b1;
            else if (pop)                     r_out_vld <= 1'b0;
        end
    end

    // Sine and cosine from the CORDIC registers
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sin[k] = r_y[k][31:0];
            w_cos[k] = r_negc[k] ? -r_x[k][31:0] : r_x[k][31:0];
        end
        w_sh = 5'(r_cnt);
        w_at = 28'(erpt_pkg::atan_deg(w_sh));
    end

    // Multiplier operand select; index 0 roll, 1 pitch, 2 yaw
    always_comb begin
        w_op  = erpt_pkg::mat_op(r_step);
        w_idx = 4'(r_step - erpt_pkg::MAT_STEPS);
        w_a   = '0;
        w_b   = '0;
        if (r_step < erpt_pkg::MAT_STEPS) begin
            case (w_op.a)
                erpt_pkg::SRC_CY: w_a = w_cos[2];
                erpt_pkg::SRC_SY: w_a = w_sin[2];
                erpt_pkg::SRC_CP: w_a = w_cos[1];
                erpt_pkg::SRC_SP: w_a = w_sin[1];
                erpt_pkg::SRC_CR: w_a = w_cos[0];
                erpt_pkg::SRC_SR: w_a = w_sin[0];
                erpt_pkg::SRC_TA: w_a = r_ta;
                erpt_pkg::SRC_TB: w_a = r_tb;
                default:          w_a = '0;
            endcase
            case (w_op.b)
                erpt_pkg::SRC_CY: w_b = w_cos[2];
                erpt_pkg::SRC_SY: w_b = w_sin[2];
                erpt_pkg::SRC_CP: w_b = w_cos[1];
                erpt_pkg::SRC_SP: w_b = w_sin[1];
                erpt_pkg::SRC_CR: w_b = w_cos[0];
                erpt_pkg::SRC_SR: w_b = w_sin[0];
                erpt_pkg::SRC_TA: w_b = r_ta;
                erpt_pkg::SRC_TB: w_b = r_tb;
                default:          w_b = '0;
            endcase
        end else begin
            // Matrix entry rounded to Q28 times camera coordinate
            w_a = 32'((r_m[w_idx] + 34'sd2) >>> 2);
            w_b = r_cam[erpt_pkg::pt_col(w_idx)];
        end
    end

    // Write-back decode, product rounded back to Q30
    always_comb begin
        w_wb_op  = erpt_pkg::mat_op(r_wb_step);
        w_wb_idx = 4'(r_wb_step - erpt_pkg::MAT_STEPS);
        w_rv     = 34'((r_prod + 64'sd536870912) >>> 30);
    end

    // Scale by 1000 in shifts, round, add offset, clamp
    always_comb begin
        w_any_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            w_p[j]  = (56'(r_t[j]) <<< 10) - (56'(r_t[j]) <<< 4) - (56'(r_t[j]) <<< 3);
            w_wv[j] = 48'((w_p[j] + 56'sd512) >>> 10) + 48'(r_eff[j]);
            if (r_w[j] > 48'sd2147483647) begin
                w_sat[j]  = 32'sh7FFFFFFF;
                w_any_sat = 1'b1;
            end else if (r_w[j] < -48'sd2147483648) begin
                w_sat[j]  = 32'sh80000000;
                w_any_sat = 1'b1;
            end else begin
                w_sat[j]  = r_w[j][31:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            erpt_pkg::ST_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_x[k]    <= erpt_pkg::CORDIC_K;
                    r_y[k]    <= '0;
                    r_z[k]    <= $signed(i_q_item.ang[k]);
                    r_negc[k] <= i_q_item.negc[k];
                    r_cam[k]  <= $signed(i_q_item.cam[k]);
                    r_eff[k]  <= $signed(i_q_item.eff[k]);
                    r_acc[k]  <= '0;
                end
            end
            erpt_pkg::ST_TRIG: begin
                for (int k = 0; k < 3; k++) begin
                    if (!r_z[k][27]) begin
                        r_x[k] <= r_x[k] - (r_y[k] >>> w_sh);
                        r_y[k] <= r_y[k] + (r_x[k] >>> w_sh);
                        r_z[k] <= r_z[k] - w_at;
                    end else begin
                        r_x[k] <= r_x[k] + (r_y[k] >>> w_sh);
                        r_y[k] <= r_y[k] - (r_x[k] >>> w_sh);
                        r_z[k] <= r_z[k] + w_at;
                    end
                end
            end
            erpt_pkg::ST_ROUND: begin
                for (int j = 0; j < 3; j++) begin
                    r_t[j] <= 46'((r_acc[j] + 64'sd131072) >>> 18);
                end
            end
            erpt_pkg::ST_SCALE: begin
                for (int j = 0; j < 3; j++) r_w[j] <= w_wv[j];
            end
            default: begin
            end
        endcase

        // Shared multiplier, one product per cycle
        if (r_state == erpt_pkg::ST_MAT) begin
            r_prod <= w_a * w_b;
            if (r_step == 5'd0) r_m[6] <= -34'(w_sin[1]);
        end

        // Product write-back
        if (r_wb_vld) begin
            if (r_wb_step < erpt_pkg::MAT_STEPS) begin
                if (w_wb_op.dst == erpt_pkg::DST_TA) begin
                    r_ta <= w_rv[31:0];
                end else if (w_wb_op.dst == erpt_pkg::DST_TB) begin
                    r_tb <= w_rv[31:0];
                end else begin
                    case (w_wb_op.mode)
                        erpt_pkg::WB_ADD: r_m[w_wb_op.dst] <= r_m[w_wb_op.dst] + w_rv;
                        erpt_pkg::WB_SUB: r_m[w_wb_op.dst] <= r_m[w_wb_op.dst] - w_rv;
                        default:          r_m[w_wb_op.dst] <= w_rv;
                    endcase
                end
            end else begin
                r_acc[erpt_pkg::pt_row(w_wb_idx)] <= r_acc[erpt_pkg::pt_row(w_wb_idx)] + r_prod;
            end
        end

        // Result word
        if (w_out_load) begin
            r_ox   <= w_sat[0];
            r_oy   <= w_sat[1];
            r_oz   <= w_sat[2];
            r_osat <= w_any_sat;
        end
    end

    assign empty       = !r_out_vld;
    assign o_world_x   = r_ox;
    assign o_world_y   = r_oy;
    assign o_world_z   = r_oz;
    assign o_saturated = r_osat;

endmodule

@@ sv/euler_rigid_point_transform.sv @@
// The engine takes one word at a time and accepts the next only once the result
// is loaded; the pace is set by the CORDIC loop and the 23 products that share
// one 32x32 multiplier.
// The input queue holds two words and the result register one, so input and
// output stall independently. Reset is synchronous, active low, and clears
// only control state.
// ----------------------------------------------------------------------------
// euler_rigid_point_transform: camera point to world point
// Scales a camera point to millimeters, rotates it by Rz*Ry*Rx from Euler
// angles in degrees and adds the end effector position, with saturation.
// ----------------------------------------------------------------------------
module euler_rigid_point_transform #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   i_cam_x,
    input  logic signed [31:0]   i_cam_y,
    input  logic signed [31:0]   i_cam_z,
    input  logic signed [31:0]   i_eff_x,
    input  logic signed [31:0]   i_eff_y,
    input  logic signed [31:0]   i_eff_z,
    input  logic signed [25:0]   i_roll_deg,
    input  logic signed [25:0]   i_pitch_deg,
    input  logic signed [25:0]   i_yaw_deg,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   o_world_x,
    output logic signed [31:0]   o_world_y,
    output logic signed [31:0]   o_world_z,
    output logic                 o_saturated
);

    logic            w_q_vld;
    logic            w_q_pop;
    erpt_pkg::t_item w_q_item;

    // Input side: classify and queue
    erpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cam_x     (i_cam_x),
        .i_cam_y     (i_cam_y),
        .i_cam_z     (i_cam_z),
        .i_eff_x     (i_eff_x),
        .i_eff_y     (i_eff_y),
        .i_eff_z     (i_eff_z),
        .i_roll_deg  (i_roll_deg),
        .i_pitch_deg (i_pitch_deg),
        .i_yaw_deg   (i_yaw_deg),
        .o_vld       (w_q_vld),
        .o_item      (w_q_item),
        .i_pop       (w_q_pop)
    );

    // Back end: trig, matrix, transform
    erpt_engine #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (w_q_vld),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_world_z   (o_world_z),
        .o_saturated (o_saturated)
    );

endmodule

@@ verif/euler_rigid_point_transform_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_rigid_point_transform_tb: self-checking bench for the point transform
// Feeds camera points, offsets and Euler angles through the push/full queue,
// predicts each world point with a local CORDIC and matrix model, and checks
// every popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module euler_rigid_point_transform_tb;

    localparam int TRIG_STEPS = 16;
    localparam int N_RANDOM   = 2000;
    localparam int LATENCY    = TRIG_STEPS + 28;

    localparam longint ANG360 = 64'sd23592960;
    localparam longint ANG180 = 64'sd11796480;
    localparam longint ANG90  = 64'sd5898240;
    localparam longint ANG_K  = 64'sd652032874;

    typedef struct {
        logic signed [31:0] cam [3];
        logic signed [31:0] eff [3];
        logic signed [25:0] ang [3];   // roll, pitch, yaw
    } t_point_word;

    typedef struct {
        logic signed [31:0] w [3];
        logic               sat;
    } t_world_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty;
    logic signed [31:0] i_cam_x = '0, i_cam_y = '0, i_cam_z = '0;
    logic signed [31:0] i_eff_x = '0, i_eff_y = '0, i_eff_z = '0;
    logic signed [25:0] i_roll_deg = '0, i_pitch_deg = '0, i_yaw_deg = '0;
    logic signed [31:0] o_world_x, o_world_y, o_world_z;
    logic               o_saturated;

    t_point_word pending_points [$];
    t_world_word expected_world [$];
    int          mismatches = 0;
    bit          feed_done = 0;

    euler_rigid_point_transform #(.TRIG_STEPS(TRIG_STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cam_x(i_cam_x), .i_cam_y(i_cam_y), .i_cam_z(i_cam_z),
        .i_eff_x(i_eff_x), .i_eff_y(i_eff_y), .i_eff_z(i_eff_z),
        .i_roll_deg(i_roll_deg), .i_pitch_deg(i_pitch_deg), .i_yaw_deg(i_yaw_deg),
        .empty(empty), .pop(pop),
        .o_world_x(o_world_x), .o_world_y(o_world_y), .o_world_z(o_world_z),
        .o_saturated(o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // Arctangent of 2^-i in Q16.16 degrees
    function automatic longint atan_step(int i);
        longint tbl [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58665, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7, 4, 2, 1};
        return (i < 23) ? tbl[i] : 64'sd0;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    // Reduce to [-90,90] with cosine sign, then rotation-mode CORDIC
    function automatic void cordic_sincos(input longint a, output longint sn,
                                          output longint cs);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = a % ANG360;
        flip = 0;
        if (r < 0) r += ANG360;
        if (r >= ANG180) r -= ANG360;
        if (r > ANG90) begin
            r = ANG180 - r;
            flip = 1;
        end else if (r < -ANG90) begin
            r = -ANG180 - r;
            flip = 1;
        end
        x = ANG_K;
        y = 0;
        z = r;
        for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function automatic t_world_word transform_point(t_point_word p);
        t_world_word res;
        longint sr, cr, sp, cp, sy, cy, acc, t, w;
        longint m [3][3];
        cordic_sincos(longint'(p.ang[0]), sr, cr);
        cordic_sincos(longint'(p.ang[1]), sp, cp);
        cordic_sincos(longint'(p.ang[2]), sy, cy);
        m[0][0] = q30_mul(cy, cp);
        m[0][1] = q30_mul(q30_mul(cy, sp), sr) - q30_mul(sy, cr);
        m[0][2] = q30_mul(q30_mul(cy, sp), cr) + q30_mul(sy, sr);
        m[1][0] = q30_mul(sy, cp);
        m[1][1] = q30_mul(q30_mul(sy, sp), sr) + q30_mul(cy, cr);
        m[1][2] = q30_mul(q30_mul(sy, sp), cr) - q30_mul(cy, sr);
        m[2][0] = -sp;
        m[2][1] = q30_mul(cp, sr);
        m[2][2] = q30_mul(cp, cr);
        res.sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += round_shift(m[j][k], 2) * longint'(p.cam[k]);
            t = round_shift(acc, 18);
            w = round_shift(t * 1000, 10) + longint'(p.eff[j]);
            if (w > 64'sd2147483647) begin
                w = 64'sd2147483647; res.sat = 1'b1;
            end
            if (w < -64'sd2147483648) begin
                w = -64'sd2147483648; res.sat = 1'b1;
            end
            res.w[j] = w[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic signed [25:0] rand_angle();
        if ($urandom_range(0, 9) == 0) return 26'($urandom);  // full 26-bit span
        return 26'($signed($urandom_range(0, 47185920)) - 32'sd23592960);
    endfunction

    task automatic add_point(input t_point_word p);
        pending_points.push_back(p);
    endtask

    // Stimulus: directed corners, then random points
    initial begin
        t_point_word p;
        logic signed [25:0] corner_ang [8] = '{26'sd0, 26'sd5898240, -26'sd5898240,
            26'sd11796480, -26'sd11796480, 26'sd23592960, -26'sd23592960,
            26'sh1FF_FFFF};
        for (int i = 0; i < 8; i++) begin
            p.cam = '{32'sh0001_0000, 32'sh0002_0000, -32'sh0001_8000};
            p.eff = '{32'sd0, 32'sh0010_0000, -32'sh0010_0000};
            p.ang = '{corner_ang[i], corner_ang[(i + 3) % 8], corner_ang[(i + 5) % 8]};
            add_point(p);
        end
        // Extreme coordinates drive saturation both ways
        p.cam = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        p.eff = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        p.ang = '{26'sd0, 26'sd0, 26'sd0};
        add_point(p);
        p.cam = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        p.eff = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        add_point(p);
        p.ang = '{26'sh200_0000, 26'sh1FF_FFFF, 26'sh200_0000};
        add_point(p);
        p.cam = '{32'sd0, 32'sd0, 32'sd0};
        p.eff = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1};
        add_point(p);
        p.cam = '{-32'sd1, 32'sd1, -32'sd1};
        p.eff = '{32'sd0, 32'sd0, 32'sd0};
        p.ang = '{26'sd2949120, -26'sd2949120, 26'sd17694720};
        add_point(p);
        for (int i = 0; i < N_RANDOM; i++) begin
            for (int j = 0; j < 3; j++) begin
                p.cam[j] = rand_coord($urandom_range(0, 2));
                p.eff[j] = rand_coord($urandom_range(0, 2));
                p.ang[j] = rand_angle();
            end
            add_point(p);
        end
        feed_done = 1;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: bursts of pushes separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_point_word nx;
        if (push && !full) expected_world.push_back(transform_point('{
            cam: '{i_cam_x, i_cam_y, i_cam_z}, eff: '{i_eff_x, i_eff_y, i_eff_z},
            ang: '{i_roll_deg, i_pitch_deg, i_yaw_deg}}));
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (pending_points.size() > 0) begin
                nx = pending_points.pop_front();
                {i_cam_x, i_cam_y, i_cam_z} <= {nx.cam[0], nx.cam[1], nx.cam[2]};
                {i_eff_x, i_eff_y, i_eff_z} <= {nx.eff[0], nx.eff[1], nx.eff[2]};
                {i_roll_deg, i_pitch_deg, i_yaw_deg} <= {nx.ang[0], nx.ang[1], nx.ang[2]};
                push <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pops on its own stall pattern and checks each word
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_world_word exp_w;
        if (pop && !empty) begin
            if (expected_world.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                exp_w = expected_world.pop_front();
                if (o_world_x !== exp_w.w[0] || o_world_y !== exp_w.w[1] ||
                    o_world_z !== exp_w.w[2] || o_saturated !== exp_w.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                                 exp_w.w[0], exp_w.w[1], exp_w.w[2], exp_w.sat,
                                 o_world_x, o_world_y, o_world_z, o_saturated);
                end
            end
        end
        stall_phase <= (stall_phase + 1) % 512;
        if (!i_rst_n) pop <= 1'b0;
        else if (stall_phase < 128) pop <= 1'b1;
        else pop <= ($urandom_range(0, 3) != 0) && ((stall_phase % 97) > 20);
    end

    // Completion
    initial begin
        wait (feed_done && i_rst_n);
        @(posedge i_clk);
        while (pending_points.size() > 0 || push || expected_world.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (mismatches == 0 && expected_world.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
sv/erpt_pkg.sv
sv/erpt_front.sv
sv/erpt_engine.sv
sv/euler_rigid_point_transform.sv
verif/euler_rigid_point_transform_tb.sv
